// File: rtl/shs_pkg.sv
package shs_pkg;

    localparam int TABLE_ENTRIES = 1024;
    localparam int TABLE_AW      = $clog2(TABLE_ENTRIES);
    localparam int HANDLE_COUNT  = 1024;
    localparam int HANDLE_AW     = $clog2(HANDLE_COUNT);
    localparam int MAX_KEY_BYTES = 8;
    localparam int HANDLE_W      = 10;
    localparam int KEY_W         = 64;
    localparam int LEN_W         = 4;
    localparam int HASH_W        = 32;
    localparam int LIMIT_W       = 7;

    localparam logic [HASH_W-1:0] HASH_SEED = 32'd5381;
    localparam logic [LIMIT_W-1:0] LIMIT_RESET = 7'd16;

    localparam logic [1:0] OP_INSERT = 2'd0;
    localparam logic [1:0] OP_REMOVE = 2'd1;
    localparam logic [1:0] OP_LOOKUP = 2'd2;

    localparam logic [1:0] STATUS_OK   = 2'd0;
    localparam logic [1:0] STATUS_FULL = 2'd1;
    localparam logic [1:0] STATUS_MISS = 2'd2;

    localparam logic [1:0] TAG_EMPTY = 2'd0;
    localparam logic [1:0] TAG_USED  = 2'd1;
    localparam logic [1:0] TAG_TOMB  = 2'd2;

    typedef struct packed {
        logic [1:0]          tag;
        logic [HANDLE_W-1:0] handle;
        logic [HASH_W-1:0]   hash;
        logic [KEY_W-1:0]    key;
        logic [LEN_W-1:0]    len;
    } slot_t;

    localparam int SLOT_W = $bits(slot_t);

endpackage

// File: rtl/shs_ram.sv
module shs_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: rtl/shadowing_symbol_hash_table_top.sv
// Symbol hash table: insert, remove and lookup of keys of up to eight bytes, one word at a
// time. After reset the block clears every entry of its slot and shadow memories and
// holds s_tready low meanwhile; configuration writes are taken at any time. An item is
// accepted, its key is hashed byte by byte with djb2a, and each probed slot is read from
// the slot memory (a registered read) and then compared. A remove that hits then reads
// the shadow memory and the next slot, and writes back. Last the result is posted to the
// output register, which waits until an earlier result held there has been taken.
// One item is worked on at a time; a finished result waits in the output register while
// the next word is taken.
module shadowing_symbol_hash_table_top
    import shs_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // operation[1:0], key_bytes[65:2], key_length[69:66], handle[79:70]
    input  logic [79:0]  s_tdata,
    output logic         m_tvalid,
    input  logic         m_tready,
    // status[1:0], found_handle[11:2], did_shadow[12], zero[15:13]
    output logic [15:0]  m_tdata,
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [6:0]   cfg_data
);

    localparam logic [2:0] ST_CLEAR  = 3'd0;
    localparam logic [2:0] ST_IDLE   = 3'd1;
    localparam logic [2:0] ST_HASH   = 3'd2;
    localparam logic [2:0] ST_READ   = 3'd3;
    localparam logic [2:0] ST_CHECK  = 3'd4;
    localparam logic [2:0] ST_RD_REM = 3'd5;
    localparam logic [2:0] ST_REM    = 3'd6;
    localparam logic [2:0] ST_DONE   = 3'd7;

    logic [2:0]          state_reg;
    logic [TABLE_AW-1:0] clr_cnt_reg;
    logic [LIMIT_W-1:0]  limit_reg;
    logic [1:0]          op_reg;
    logic [KEY_W-1:0]    key_reg;
    logic [KEY_W-1:0]    key_sh_reg;
    logic [LEN_W-1:0]    len_reg;
    logic [LEN_W-1:0]    cnt_reg;
    logic [HANDLE_W-1:0] hdl_reg;
    logic [HASH_W-1:0]   hash_reg;
    logic [TABLE_AW-1:0] idx_reg;
    logic [LIMIT_W:0]    reprobe_reg;
    slot_t               hit_reg;
    logic [1:0]          res_status_reg;
    logic [HANDLE_W-1:0] res_found_reg;
    logic                res_shadow_reg;
    logic                out_valid_reg;
    logic [15:0]         out_data_reg;

    logic [1:0]          in_op;
    logic [KEY_W-1:0]    in_key;
    logic [LEN_W-1:0]    in_len;
    logic [LEN_W-1:0]    len_clamped;
    logic [HANDLE_W-1:0] in_hdl;
    logic [KEY_W-1:0]    key_masked;
    logic                in_work;

    logic                slot_we;
    logic [TABLE_AW-1:0] slot_waddr;
    slot_t               slot_wdata;
    logic                slot_re;
    logic [TABLE_AW-1:0] slot_raddr;
    slot_t               slot_rd;
    logic [SLOT_W-1:0]   slot_rdata;
    logic                sh_we;
    logic [HANDLE_AW-1:0] sh_waddr;
    logic [HANDLE_W-1:0] sh_wdata;
    logic                sh_re;
    logic [HANDLE_AW-1:0] sh_raddr;
    logic [HANDLE_W-1:0] sh_rdata;

    logic                key_match;
    logic                hdl_match;
    logic [LIMIT_W:0]    reprobe_inc;
    logic                over_limit;
    logic                out_free;
    logic [HASH_W-1:0]   hash_step;

    assign in_op  = s_tdata[1:0];
    assign in_key = s_tdata[65:2];
    assign in_len = s_tdata[69:66];
    assign in_hdl = s_tdata[79:70];
    assign len_clamped = (in_len > LEN_W'(MAX_KEY_BYTES)) ? LEN_W'(MAX_KEY_BYTES) : in_len;

    always_comb
    begin
        for (int i = 0; i < MAX_KEY_BYTES; i++)
        begin
            key_masked[8*i +: 8] = (LEN_W'(i) < len_clamped) ? in_key[8*i +: 8] : 8'd0;
        end
        for (int i = MAX_KEY_BYTES; i < 8; i++)
        begin
            key_masked[8*i +: 8] = 8'd0;
        end
    end

    assign in_work = (in_op == OP_LOOKUP) ||
                     ((in_op == OP_INSERT || in_op == OP_REMOVE) && in_hdl != '0);

    assign s_tready  = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_tvalid  = out_valid_reg;
    assign m_tdata   = out_data_reg;
    assign out_free  = !out_valid_reg || m_tready;

    assign slot_rd     = slot_t'(slot_rdata);
    assign key_match   = slot_rd.tag == TAG_USED && slot_rd.hash == hash_reg &&
                         slot_rd.len == len_reg && slot_rd.key == key_reg;
    assign hdl_match   = slot_rd.tag == TAG_USED && slot_rd.handle == hdl_reg;
    assign reprobe_inc = reprobe_reg + 1'b1;
    assign over_limit  = reprobe_inc > {1'b0, limit_reg};
    // h * 33 is a shift and an add.
    assign hash_step   = ((hash_reg << 5) + hash_reg) ^ {24'd0, key_sh_reg[7:0]};

    always_comb
    begin
        slot_we    = 1'b0;
        slot_waddr = idx_reg;
        slot_wdata = '0;
        slot_re    = 1'b0;
        slot_raddr = idx_reg;
        sh_we      = 1'b0;
        sh_waddr   = hdl_reg[HANDLE_AW-1:0];
        sh_wdata   = '0;
        sh_re      = 1'b0;
        sh_raddr   = hdl_reg[HANDLE_AW-1:0];
        case (state_reg)
            ST_CLEAR:
            begin
                slot_we    = 1'b1;
                slot_waddr = clr_cnt_reg;
                sh_we      = 1'b1;
                sh_waddr   = clr_cnt_reg;
            end
            ST_READ:
            begin
                slot_re = 1'b1;
            end
            ST_CHECK:
            begin
                if (op_reg == OP_INSERT)
                begin
                    if (slot_rd.tag != TAG_USED)
                    begin
                        slot_we    = 1'b1;
                        slot_wdata = '{tag: TAG_USED, handle: hdl_reg, hash: hash_reg,
                                       key: key_reg, len: len_reg};
                        sh_we      = 1'b1;
                    end
                    else if (key_match)
                    begin
                        slot_we           = 1'b1;
                        slot_wdata        = slot_rd;
                        slot_wdata.handle = hdl_reg;
                        sh_we             = 1'b1;
                        sh_wdata          = slot_rd.handle;
                    end
                end
            end
            ST_RD_REM:
            begin
                slot_re    = 1'b1;
                slot_raddr = idx_reg + 1'b1;
                sh_re      = 1'b1;
            end
            ST_REM:
            begin
                slot_we           = 1'b1;
                slot_wdata        = hit_reg;
                slot_wdata.handle = sh_rdata;
                if (sh_rdata == '0)
                begin
                    // A free slot becomes a tombstone only when the chain goes on past it.
                    if (slot_rd.tag != TAG_EMPTY)
                    begin
                        slot_wdata.tag  = TAG_TOMB;
                        slot_wdata.hash = '0;
                    end
                    else
                    begin
                        slot_wdata.tag = TAG_EMPTY;
                    end
                end
                sh_we = 1'b1;
            end
            default:
            begin
            end
        endcase
    end

    shs_ram #(
        .WIDTH(SLOT_W),
        .DEPTH(TABLE_ENTRIES)
    ) u_slot_ram (
        .clk  (clk),
        .we   (slot_we),
        .waddr(slot_waddr),
        .wdata(SLOT_W'(slot_wdata)),
        .re   (slot_re),
        .raddr(slot_raddr),
        .rdata(slot_rdata)
    );

    shs_ram #(
        .WIDTH(HANDLE_W),
        .DEPTH(HANDLE_COUNT)
    ) u_shadow_ram (
        .clk  (clk),
        .we   (sh_we),
        .waddr(sh_waddr),
        .wdata(sh_wdata),
        .re   (sh_re),
        .raddr(sh_raddr),
        .rdata(sh_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clr_cnt_reg   <= '0;
            limit_reg     <= LIMIT_RESET;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_valid)
            begin
                limit_reg <= cfg_data;
            end
            if (out_valid_reg && m_tready && state_reg != ST_DONE)
            begin
                out_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_CLEAR:
                begin
                    clr_cnt_reg <= clr_cnt_reg + 1'b1;
                    if (clr_cnt_reg == TABLE_AW'(TABLE_ENTRIES - 1))
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                ST_IDLE:
                begin
                    if (s_tvalid)
                    begin
                        op_reg         <= in_op;
                        key_reg        <= key_masked;
                        key_sh_reg     <= key_masked;
                        len_reg        <= len_clamped;
                        cnt_reg        <= len_clamped;
                        hdl_reg        <= in_hdl;
                        hash_reg       <= HASH_SEED;
                        res_status_reg <= STATUS_MISS;
                        res_found_reg  <= '0;
                        res_shadow_reg <= 1'b0;
                        state_reg      <= in_work ? ST_HASH : ST_DONE;
                    end
                end
                ST_HASH:
                begin
                    if (cnt_reg == '0)
                    begin
                        idx_reg     <= hash_reg[TABLE_AW-1:0];
                        reprobe_reg <= '0;
                        state_reg   <= ST_READ;
                    end
                    else
                    begin
                        hash_reg   <= hash_step;
                        key_sh_reg <= key_sh_reg >> 8;
                        cnt_reg    <= cnt_reg - 1'b1;
                    end
                end
                ST_READ:
                begin
                    state_reg <= ST_CHECK;
                end
                ST_CHECK:
                begin
                    case (op_reg)
                        OP_INSERT:
                        begin
                            if (slot_rd.tag != TAG_USED)
                            begin
                                res_status_reg <= STATUS_OK;
                                state_reg      <= ST_DONE;
                            end
                            else if (key_match)
                            begin
                                res_status_reg <= STATUS_OK;
                                res_found_reg  <= slot_rd.handle;
                                res_shadow_reg <= 1'b1;
                                state_reg      <= ST_DONE;
                            end
                            else if (over_limit)
                            begin
                                res_status_reg <= STATUS_FULL;
                                state_reg      <= ST_DONE;
                            end
                            else
                            begin
                                idx_reg     <= idx_reg + 1'b1;
                                reprobe_reg <= reprobe_inc;
                                state_reg   <= ST_READ;
                            end
                        end
                        OP_REMOVE:
                        begin
                            if (slot_rd.tag == TAG_EMPTY)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else if (hdl_match)
                            begin
                                hit_reg   <= slot_rd;
                                state_reg <= ST_RD_REM;
                            end
                            else if (!over_limit)
                            begin
                                idx_reg     <= idx_reg + 1'b1;
                                reprobe_reg <= reprobe_inc;
                                state_reg   <= ST_READ;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                        default:
                        begin
                            if (slot_rd.tag == TAG_EMPTY)
                            begin
                                state_reg <= ST_DONE;
                            end
                            else if (key_match)
                            begin
                                res_status_reg <= STATUS_OK;
                                res_found_reg  <= slot_rd.handle;
                                state_reg      <= ST_DONE;
                            end
                            else if (!over_limit)
                            begin
                                idx_reg     <= idx_reg + 1'b1;
                                reprobe_reg <= reprobe_inc;
                                state_reg   <= ST_READ;
                            end
                            else
                            begin
                                state_reg <= ST_DONE;
                            end
                        end
                    endcase
                end
                ST_RD_REM:
                begin
                    state_reg <= ST_REM;
                end
                ST_REM:
                begin
                    res_status_reg <= STATUS_OK;
                    state_reg      <= ST_DONE;
                end
                ST_DONE:
                begin
                    if (out_free)
                    begin
                        out_valid_reg <= 1'b1;
                        out_data_reg  <= {3'd0, res_shadow_reg, res_found_reg, res_status_reg};
                        state_reg     <= ST_IDLE;
                    end
                end
                default:
                begin
                    state_reg <= ST_IDLE;
                end
            endcase
        end
    end

endmodule
